FILE: hdl/midi_note_span_pairing_core_assert.svh
// assertion macros for the note span pairing core
// used by the top level; needs no other file
`ifndef MIDI_NOTE_SPAN_PAIRING_CORE_ASSERT_SVH
`define MIDI_NOTE_SPAN_PAIRING_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define MNSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// antecedent implies consequent in the next cycle
`define MNSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MNSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MNSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/mnsp_pkg.sv
// shared types and constants of the note span pairing core
// no dependencies
package mnsp_pkg;

    localparam int STACK_DEPTH_DEF = 4;
    localparam int TICK_BITS_DEF   = 31;

    localparam int KEY_W     = 11;
    localparam int KEY_COUNT = 1 << KEY_W;

    localparam logic [7:0] STATUS_TYPE_MASK = 8'hF0;
    localparam logic [7:0] STATUS_CHAN_MASK = 8'h0F;
    localparam logic [7:0] MSG_NOTE_ON      = 8'h90;
    localparam logic [7:0] MSG_NOTE_OFF     = 8'h80;
    localparam logic [1:0] LEN_FULL         = 2'd3;

    localparam logic RES_SPAN = 1'b0;
    localparam logic RES_DROP = 1'b1;

    typedef struct packed {
        logic        is_push;
        logic [3:0]  chan;
        logic [6:0]  pitch;
        logic [6:0]  vel;
        logic [30:0] tick;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [30:0] start;
        logic [31:0] stop;
        logic [6:0]  pitch;
        logic [6:0]  vel;
        logic [3:0]  chan;
    } t_res;

endpackage

FILE: hdl/mnsp_front.sv
// front end: filters and classifies midi events into a two-entry command queue
// depends on mnsp_pkg
module mnsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_hold,
    input  logic [7:0]        i_status_byte,
    input  logic [7:0]        i_data_one,
    input  logic [7:0]        i_data_two,
    input  logic [1:0]        i_event_length,
    input  logic [30:0]       i_event_tick,
    output logic              o_full,
    output logic              o_cmd_valid,
    output mnsp_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);

    mnsp_pkg::t_cmd r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_fill;

    logic [7:0]     msg_type;
    logic           is_note;
    logic           accept;
    logic           wr_en;
    mnsp_pkg::t_cmd cmd_in;

    always_comb begin
        msg_type = i_status_byte & mnsp_pkg::STATUS_TYPE_MASK;
        is_note  = (i_event_length == mnsp_pkg::LEN_FULL) && !i_data_one[7] && !i_data_two[7]
                   && (msg_type inside {mnsp_pkg::MSG_NOTE_ON, mnsp_pkg::MSG_NOTE_OFF});
        cmd_in.is_push = (msg_type == mnsp_pkg::MSG_NOTE_ON) && (i_data_two != 8'd0);
        cmd_in.chan    = 4'(i_status_byte & mnsp_pkg::STATUS_CHAN_MASK);
        cmd_in.pitch   = i_data_one[6:0];
        cmd_in.vel     = i_data_two[6:0];
        cmd_in.tick    = i_event_tick;
    end

    assign o_full      = (r_fill == 2'd2) || i_hold;
    assign accept      = i_push && !o_full;
    assign wr_en       = accept && is_note;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + 2'(wr_en) - 2'(i_cmd_pop);
        end
    end

endmodule

FILE: hdl/mnsp_back.sv
// back end: per-key note stacks in memory, sequencer doing read-modify-write
// depends on mnsp_pkg
module mnsp_back #(
    parameter int STACK_DEPTH = mnsp_pkg::STACK_DEPTH_DEF,
    parameter int TICK_BITS   = mnsp_pkg::TICK_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  mnsp_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_push,
    output mnsp_pkg::t_res    o_res,
    input  logic              i_res_full,
    output logic              o_clearing
);

    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W  = $clog2((STACK_DEPTH > 1) ? STACK_DEPTH : 2);
    localparam int ENT_W   = TICK_BITS + 7;
    localparam int STK_A_W = mnsp_pkg::KEY_W + SLOT_W;
    localparam int STK_N   = 1 << STK_A_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CNT,
        S_STK
    } t_state;

    t_state                      r_state, n_state;
    mnsp_pkg::t_cmd              r_cmd, n_cmd;
    logic                        r_clearing, n_clearing;
    logic [mnsp_pkg::KEY_W-1:0]  r_clr_addr, n_clr_addr;

    logic [CNT_W-1:0]            r_cnt_mem [mnsp_pkg::KEY_COUNT];
    logic [CNT_W-1:0]            r_cnt_q;
    logic [ENT_W-1:0]            r_stk_mem [STK_N];
    logic [ENT_W-1:0]            r_stk_q;

    logic                        cnt_re;
    logic                        cnt_upd;
    logic                        cnt_we;
    logic [mnsp_pkg::KEY_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]            cnt_new;
    logic [CNT_W-1:0]            cnt_wdata;
    logic [CNT_W-1:0]            cnt_dec;
    logic                        stk_we;
    logic                        stk_re;
    logic [STK_A_W-1:0]          stk_addr;
    logic [mnsp_pkg::KEY_W-1:0]  key_in;
    logic [mnsp_pkg::KEY_W-1:0]  key_cur;
    logic [TICK_BITS-1:0]        tick_m;
    logic [TICK_BITS-1:0]        stk_tick;
    logic [TICK_BITS:0]          later;
    logic [TICK_BITS:0]          span_end;

    assign key_in     = {i_cmd.chan, i_cmd.pitch};
    assign key_cur    = {r_cmd.chan, r_cmd.pitch};
    assign tick_m     = r_cmd.tick[TICK_BITS-1:0];
    assign stk_tick   = r_stk_q[ENT_W-1:7];
    assign later      = {1'b0, stk_tick} + (TICK_BITS+1)'(1);
    assign span_end   = ({1'b0, tick_m} > later) ? {1'b0, tick_m} : later;
    assign cnt_dec    = r_cnt_q - CNT_W'(1);
    assign o_clearing = r_clearing;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        cnt_re     = 1'b0;
        cnt_upd    = 1'b0;
        cnt_new    = r_cnt_q;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_addr   = {key_cur, r_cnt_q[SLOT_W-1:0]};
        o_res_push = 1'b0;
        o_res      = '0;

        if (r_clearing) begin
            n_clr_addr = r_clr_addr + mnsp_pkg::KEY_W'(1);
            if (r_clr_addr == '1) begin
                n_clearing = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_clearing) begin
                    cnt_re  = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = S_CNT;
                end
            end
            S_CNT: begin
                if (r_cmd.is_push) begin
                    if (r_cnt_q >= CNT_W'(STACK_DEPTH)) begin
                        // stack full: report the dropped note-on
                        o_res.kind  = mnsp_pkg::RES_DROP;
                        o_res.start = 31'(tick_m);
                        o_res.stop  = '0;
                        o_res.pitch = r_cmd.pitch;
                        o_res.vel   = r_cmd.vel;
                        o_res.chan  = r_cmd.chan;
                        o_res_push  = !i_res_full;
                        if (!i_res_full) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        stk_we  = 1'b1;
                        cnt_upd = 1'b1;
                        cnt_new = r_cnt_q + CNT_W'(1);
                        n_state = S_IDLE;
                    end
                end else if (r_cnt_q == '0) begin
                    // unmatched off
                    n_state = S_IDLE;
                end else begin
                    cnt_upd  = 1'b1;
                    cnt_new  = cnt_dec;
                    stk_re   = 1'b1;
                    stk_addr = {key_cur, cnt_dec[SLOT_W-1:0]};
                    n_state  = S_STK;
                end
            end
            S_STK: begin
                o_res.kind  = mnsp_pkg::RES_SPAN;
                o_res.start = 31'(stk_tick);
                o_res.stop  = 32'(span_end);
                o_res.pitch = r_cmd.pitch;
                o_res.vel   = r_stk_q[6:0];
                o_res.chan  = r_cmd.chan;
                o_res_push  = !i_res_full;
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd_pop = cnt_re;
    assign cnt_we    = r_clearing || cnt_upd;
    assign cnt_waddr = r_clearing ? r_clr_addr : key_cur;
    assign cnt_wdata = r_clearing ? '0 : cnt_new;

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_q <= r_cnt_mem[key_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_addr] <= {tick_m, r_cmd.vel};
        end
        if (stk_re) begin
            r_stk_q <= r_stk_mem[stk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

endmodule

FILE: hdl/mnsp_outq.sv
// two-entry result queue decoupling the sequencer from the result port
// depends on mnsp_pkg
module mnsp_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mnsp_pkg::t_res    i_res,
    output logic              o_full,
    output logic              o_empty,
    input  logic              i_pop,
    output mnsp_pkg::t_res    o_res
);

    mnsp_pkg::t_res r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_fill;
    logic           wr_en;
    logic           rd_en;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_res   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

FILE: hdl/midi_note_span_pairing_core.sv
// top level of the midi note on/off pairing core
// depends on mnsp_pkg, mnsp_front, mnsp_back, mnsp_outq and the assertion header
//
//  channel   direction  handshake           payload
//  events    in         push / full         i_status_byte i_data_one i_data_two
//                                           i_event_length i_event_tick
//  spans     out        empty / pop         o_result_kind o_start_tick o_end_tick
//                                           o_note_pitch o_note_velocity o_note_channel
//
// note-on and unmatched note-off transfers pass the sequencer states idle and count, a matched
//   note-off idle, count and stack (count memory read, then stack memory read), after the
//   command queue; events that are no note message are dropped by the front end
// after reset a clearing pass zeroes the 2048 pending counts: full stays high
//   until the pass ends, then drops
// a full result queue stalls the sequencer; the two-entry command queue keeps
//   taking events until it fills
`include "midi_note_span_pairing_core_assert.svh"
module midi_note_span_pairing_core #(
    parameter int STACK_DEPTH = mnsp_pkg::STACK_DEPTH_DEF,
    parameter int TICK_BITS   = mnsp_pkg::TICK_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_status_byte,
    input  logic [7:0]  i_data_one,
    input  logic [7:0]  i_data_two,
    input  logic [1:0]  i_event_length,
    input  logic [30:0] i_event_tick,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [30:0] o_start_tick,
    output logic [31:0] o_end_tick,
    output logic [6:0]  o_note_pitch,
    output logic [6:0]  o_note_velocity,
    output logic [3:0]  o_note_channel
);

    // classified commands between front and back
    logic           cmd_valid;
    logic           cmd_pop;
    mnsp_pkg::t_cmd cmd;

    // results from the sequencer into the output queue
    logic           res_push;
    logic           res_full;
    mnsp_pkg::t_res res_in;
    mnsp_pkg::t_res res_out;

    // high while the count memory is being zeroed
    logic           clearing;

    mnsp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_hold         (clearing),
        .i_status_byte  (i_status_byte),
        .i_data_one     (i_data_one),
        .i_data_two     (i_data_two),
        .i_event_length (i_event_length),
        .i_event_tick   (i_event_tick),
        .o_full         (full),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    mnsp_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .TICK_BITS   (TICK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full),
        .o_clearing  (clearing)
    );

    mnsp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res_out)
    );

    // result fields straight off the queue head
    assign o_result_kind   = res_out.kind;
    assign o_start_tick    = res_out.start;
    assign o_end_tick      = res_out.stop;
    assign o_note_pitch    = res_out.pitch;
    assign o_note_velocity = res_out.vel;
    assign o_note_channel  = res_out.chan;

    // the sequencer never writes a result into a full queue
    `MNSP_ASSERT_SAME(a_no_res_overflow, i_clk, i_rst_n, res_push, !res_full)
    // commands are only taken from a non-empty queue
    `MNSP_ASSERT_SAME(a_no_cmd_underflow, i_clk, i_rst_n, cmd_pop, cmd_valid)
    // nothing is taken or produced during the clearing pass
    `MNSP_ASSERT_SAME(a_clear_quiet, i_clk, i_rst_n, clearing, full && empty && !cmd_pop)
    // once clearing ends it does not come back without a reset
    `MNSP_ASSERT_NEXT(a_clear_once, i_clk, i_rst_n, !clearing, !clearing)

endmodule
